FILE: sv/booth_radix2_signed_multiplier_assert.svh
// ----------------------------------------------------------------------------
// Booth multiplier assertion macros
// Shorthand for clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH

// check prop at every rising edge outside reset
`define BR2M_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("booth multiplier check failed");

// check prop at every rising edge, reset included
`define BR2M_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("booth multiplier check failed");

`endif

FILE: sv/br2m_pkg.sv
// ----------------------------------------------------------------------------
// Booth multiplier package
// Shared constants for the radix-2 Booth multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package br2m_pkg;

    localparam int WIDTH = 16;

    // Booth pair {current bit, previous bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

`default_nettype wire

FILE: sv/br2m_cell.sv
// ----------------------------------------------------------------------------
// Booth step cell
// One radix-2 Booth step with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module br2m_cell #(
    parameter int L = br2m_pkg::WIDTH + 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire logic [L-1:0] up_a,
    input  wire logic [L-1:0] up_q,
    input  wire logic [L-1:0] up_m,
    input  wire logic         up_prev,
    output logic              dn_valid,
    input  wire logic         dn_ready,
    output logic      [L-1:0] dn_a,
    output logic      [L-1:0] dn_q,
    output logic      [L-1:0] dn_m,
    output logic              dn_prev
);

    logic         valid_reg;
    logic         valid_next;
    logic [L-1:0] a_reg;
    logic [L-1:0] a_next;
    logic [L-1:0] q_reg;
    logic [L-1:0] q_next;
    logic [L-1:0] m_reg;
    logic         prev_reg;
    logic [L-1:0] sum;
    logic         load;

    assign load     = !valid_reg || dn_ready;
    assign up_ready = load;

    always_comb begin
        case ({up_q[0], up_prev})
            br2m_pkg::BOOTH_SUB: begin
                sum = up_a - up_m;
            end
            br2m_pkg::BOOTH_ADD: begin
                sum = up_a + up_m;
            end
            default: begin
                sum = up_a;
            end
        endcase
        a_next     = {sum[L-1], sum[L-1:1]};
        q_next     = {sum[0], up_q[L-1:1]};
        valid_next = load ? up_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg    <= a_next;
            q_reg    <= q_next;
            m_reg    <= up_m;
            prev_reg <= up_q[0];
        end
    end

    assign dn_valid = valid_reg;
    assign dn_a     = a_reg;
    assign dn_q     = q_reg;
    assign dn_m     = m_reg;
    assign dn_prev  = prev_reg;

endmodule

`default_nettype wire

FILE: sv/booth_radix2_signed_multiplier.sv
// ----------------------------------------------------------------------------
// Radix-2 Booth signed multiplier
// Signed WIDTH x WIDTH multiply as a chain of WIDTH+1 Booth step cells.
// ----------------------------------------------------------------------------
// The block multiplies two signed WIDTH-bit operands and returns the exact
// signed 2*WIDTH-bit product, the most negative operands included. Each of
// the WIDTH+1 cells in the chain performs one Booth step and registers it, so
// a new item is taken every cycle when the output side does not stall, and
// its product is held in the last cell, which is the output register; while
// it waits, empty cells upstream still take new items.
`default_nettype none

module booth_radix2_signed_multiplier #(
    parameter  int WIDTH   = br2m_pkg::WIDTH,
    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // multiplicand [WIDTH-1:0], multiplier [2*WIDTH-1:WIDTH]
    input  wire logic [TDATA_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // product [2*WIDTH-1:0]
    output logic      [TDATA_W-1:0] m_tdata
);

    localparam int L = WIDTH + 1;

    logic         vld_s   [0:L];
    logic         rdy_s   [0:L];
    logic [L-1:0] a_s     [0:L];
    logic [L-1:0] q_s     [0:L];
    logic [L-1:0] m_s     [0:L];
    logic         prev_s  [0:L];
    logic [2*L-1:0] full_w;

    assign vld_s[0]  = s_tvalid;
    assign s_tready  = rdy_s[0];
    assign a_s[0]    = '0;
    assign m_s[0]    = {s_tdata[WIDTH-1], s_tdata[WIDTH-1:0]};
    assign q_s[0]    = {s_tdata[2*WIDTH-1], s_tdata[2*WIDTH-1:WIDTH]};
    assign prev_s[0] = 1'b0;

    for (genvar i = 0; i < L; i++) begin : g_cell
        br2m_cell #(
            .L (L)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (vld_s[i]),
            .up_ready (rdy_s[i]),
            .up_a     (a_s[i]),
            .up_q     (q_s[i]),
            .up_m     (m_s[i]),
            .up_prev  (prev_s[i]),
            .dn_valid (vld_s[i+1]),
            .dn_ready (rdy_s[i+1]),
            .dn_a     (a_s[i+1]),
            .dn_q     (q_s[i+1]),
            .dn_m     (m_s[i+1]),
            .dn_prev  (prev_s[i+1])
        );
    end

    assign rdy_s[L]  = m_tready;
    assign m_tvalid  = vld_s[L];
    assign full_w    = {a_s[L], q_s[L]};
    assign m_tdata   = TDATA_W'(full_w[2*WIDTH-1:0]);

    // the last cell's multiplicand and previous bit are not needed at the output
    logic unused_tail;
    assign unused_tail = ^{m_s[L], prev_s[L]};

endmodule

`default_nettype wire

FILE: sv/br2m_checker.sv
// ----------------------------------------------------------------------------
// Booth multiplier port checker
// Checks the handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "booth_radix2_signed_multiplier_assert.svh"

module br2m_checker #(
    parameter  int WIDTH   = br2m_pkg::WIDTH,
    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [TDATA_W-1:0] s_tdata,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata
);

    logic unused_in;
    assign unused_in = ^{s_tvalid, s_tdata};

    `BR2M_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `BR2M_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `BR2M_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    `BR2M_ASSERT(a_ready_when_draining, aclk, aresetn, m_tready |-> s_tready)

endmodule

bind booth_radix2_signed_multiplier br2m_checker #(
    .WIDTH (WIDTH)
) u_br2m_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
